// ===== hdl/whm_pkg.sv =====
// Shared types, constants and the sine table for the windowed hydrophobic moment block.
package whm_pkg;

    // Field and register widths.
    localparam int HYDRO_W  = 12;
    localparam int MOMENT_W = 11;
    localparam int USED_W   = 6;
    localparam int WLEN_W   = 6;
    localparam int ROT_W    = 9;
    localparam int CFG_W    = 9;
    localparam int MUL_W    = 20;
    localparam int SINE_W   = 16;

    // Defaults.
    localparam int MAX_WINDOW_DEF = 32;
    localparam logic [WLEN_W-1:0] WLEN_RESET = 6'd11;
    localparam logic [ROT_W-1:0]  ROT_RESET  = 9'd100;

    // Angle constants in whole degrees.
    localparam logic [9:0] FULL_TURN    = 10'd360;
    localparam logic [9:0] HALF_TURN    = 10'd180;
    localparam logic [9:0] QUARTER_TURN = 10'd90;
    localparam logic [9:0] THREE_QUARTER = 10'd270;

    // Configuration register indexes.
    localparam logic REG_WINDOW_LENGTH = 1'b0;
    localparam logic REG_ROTATION      = 1'b1;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_MAC_SIN,
        ST_MAC_COS,
        ST_DRAIN,
        ST_SQ_LO,
        ST_SQ_MID,
        ST_SQ_HI,
        ST_SQ_END,
        ST_ROOT_MUL,
        ST_ROOT_SQ,
        ST_ROOT_CMP,
        ST_OUT
    } state_t;

    // Quarter-wave sine table, round(32767*sin(d)) for d = 0..90.
    localparam logic [15:0] QSINE [0:90] = '{
        16'd0, 16'd572, 16'd1144, 16'd1715, 16'd2286, 16'd2856, 16'd3425, 16'd3993,
        16'd4560, 16'd5126, 16'd5690, 16'd6252, 16'd6813, 16'd7371, 16'd7927, 16'd8481,
        16'd9032, 16'd9580, 16'd10126, 16'd10668, 16'd11207, 16'd11743, 16'd12275,
        16'd12803, 16'd13328, 16'd13848, 16'd14364, 16'd14876, 16'd15383, 16'd15886,
        16'd16384, 16'd16876, 16'd17364, 16'd17846, 16'd18323, 16'd18794, 16'd19260,
        16'd19720, 16'd20173, 16'd20621, 16'd21062, 16'd21497, 16'd21925, 16'd22347,
        16'd22762, 16'd23170, 16'd23571, 16'd23964, 16'd24351, 16'd24730, 16'd25101,
        16'd25465, 16'd25821, 16'd26169, 16'd26509, 16'd26841, 16'd27165, 16'd27481,
        16'd27788, 16'd28087, 16'd28377, 16'd28659, 16'd28932, 16'd29196, 16'd29451,
        16'd29697, 16'd29934, 16'd30162, 16'd30381, 16'd30591, 16'd30791, 16'd30982,
        16'd31163, 16'd31335, 16'd31498, 16'd31650, 16'd31794, 16'd31927, 16'd32051,
        16'd32165, 16'd32269, 16'd32364, 16'd32448, 16'd32523, 16'd32587, 16'd32642,
        16'd32687, 16'd32722, 16'd32747, 16'd32762, 16'd32767
    };

    // Signed Q1.15 sine of an angle already reduced below a full turn.
    function automatic logic signed [SINE_W-1:0] sine_deg(input logic [9:0] d);
        logic [9:0]  idx;
        logic        neg;
        logic [15:0] mag;
        begin
            if (d <= QUARTER_TURN)
            begin
                idx = d;
                neg = 1'b0;
            end
            else if (d <= HALF_TURN)
            begin
                idx = HALF_TURN - d;
                neg = 1'b0;
            end
            else if (d <= THREE_QUARTER)
            begin
                idx = d - HALF_TURN;
                neg = 1'b1;
            end
            else
            begin
                idx = FULL_TURN - d;
                neg = 1'b1;
            end
            mag = (idx <= QUARTER_TURN) ? QSINE[idx[6:0]] : 16'd0;
            sine_deg = neg ? -$signed(mag) : $signed(mag);
        end
    endfunction

endpackage

// ===== hdl/whm_mul.sv =====
// Shared registered signed multiplier used by the window sums, the squares and the square root.
module whm_mul
(
    input  logic                              clk,
    input  logic signed [whm_pkg::MUL_W-1:0]  op_a,
    input  logic signed [whm_pkg::MUL_W-1:0]  op_b,
    output logic signed [2*whm_pkg::MUL_W-1:0] prod
);

    logic signed [2*whm_pkg::MUL_W-1:0] prod_reg;

    // One product per cycle, registered before any use.
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    assign prod = prod_reg;

endmodule

// ===== hdl/windowed_hydrophobic_moment.sv =====
// Windowed hydrophobic moment over a window of n residues, computed by one shared 20x20
// multiplier stepping through the window sums, the squares and an 11-step bit-by-bit
// square root.
// An item that completes no window is taken in ST_IDLE and gives no result.
// One item is in work at a time; in_ready is low until the result beat is taken.
// Reset (rst_n, asynchronous, active low) sets state, write pointer, fill count and config.
module windowed_hydrophobic_moment
#(
    parameter int MAX_WINDOW = whm_pkg::MAX_WINDOW_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic                                 cfg_index,
    input  logic [whm_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [whm_pkg::HYDRO_W-1:0]   hydro_value,
    input  logic                                 seq_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [whm_pkg::MOMENT_W-1:0]         moment,
    output logic [whm_pkg::USED_W-1:0]           window_used,
    output logic                                 final_result
);

    localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int MAG_W = 26 + $clog2(MAX_WINDOW);
    localparam int ACC_W = MAG_W + 1;
    localparam int LO_W  = 17;
    localparam int HI_W  = MAG_W - LO_W;
    localparam int XW    = 2 * MAG_W + 1;
    localparam int CMP_W = 72;
    localparam int PW    = 2 * whm_pkg::MUL_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WINDOW);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(MAX_WINDOW - 1);

    whm_pkg::state_t state_reg, state_next;

    // Configuration and sequence bookkeeping.
    logic [whm_pkg::WLEN_W-1:0] wlen_reg;
    logic [whm_pkg::ROT_W-1:0]  rot_reg;
    logic [PTR_W-1:0]           wp_reg;
    logic [CNT_W-1:0]           fill_reg;

    // Work registers.
    logic [whm_pkg::HYDRO_W-1:0] store [MAX_WINDOW];
    logic signed [whm_pkg::HYDRO_W-1:0] rd_data_reg;
    logic [PTR_W-1:0]           rd_ptr_reg;
    logic [CNT_W-1:0]           n_reg;
    logic [CNT_W-1:0]           k_reg;
    logic [9:0]                 deg_reg;
    logic                       last_reg;
    logic signed [ACC_W-1:0]    s_reg;
    logic signed [ACC_W-1:0]    c_reg;
    logic                       sq_sel_reg;
    logic [XW-1:0]              x_reg;
    logic [whm_pkg::MOMENT_W-1:0] m_reg;
    logic [3:0]                 bit_reg;

    // Shared multiplier.
    logic signed [whm_pkg::MUL_W-1:0] op_a, op_b;
    logic signed [PW-1:0]             prod;

    whm_mul u_mul
    (
        .clk  (clk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    // Window clamp, fill update and window choice for the incoming item.
    logic [9:0]       wl_ext;
    logic [CNT_W-1:0] w_eff;
    logic [CNT_W-1:0] fill_new;
    logic [PTR_W-1:0] wp_new;
    logic [CNT_W-1:0] n_sel;
    logic [CNT_W:0]   start_sum;
    logic             accept;

    always_comb
    begin
        wl_ext = 10'(wlen_reg);
        if (wl_ext == 10'd0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (wl_ext > 10'(MAX_WINDOW))
        begin
            w_eff = MAX_CNT;
        end
        else
        begin
            w_eff = CNT_W'(wl_ext);
        end
        fill_new = (fill_reg < MAX_CNT) ? fill_reg + CNT_W'(1) : fill_reg;
        wp_new = (wp_reg == LAST_PTR) ? '0 : wp_reg + PTR_W'(1);
        if (fill_new >= w_eff)
        begin
            n_sel = w_eff;
        end
        else if (seq_end)
        begin
            n_sel = fill_new;
        end
        else
        begin
            n_sel = '0;
        end
        if ((CNT_W + 1)'(wp_new) >= (CNT_W + 1)'(n_sel))
        begin
            start_sum = (CNT_W + 1)'(wp_new) - (CNT_W + 1)'(n_sel);
        end
        else
        begin
            start_sum = (CNT_W + 1)'(wp_new) + (CNT_W + 1)'(MAX_WINDOW)
                        - (CNT_W + 1)'(n_sel);
        end
    end

    assign accept = in_valid && in_ready;

    // Angle helpers.
    logic [9:0] rot_mod;
    logic [9:0] deg_step;
    logic [9:0] cos_deg;

    always_comb
    begin
        rot_mod  = (10'(rot_reg) >= whm_pkg::FULL_TURN) ? 10'(rot_reg) - whm_pkg::FULL_TURN
                                                       : 10'(rot_reg);
        deg_step = deg_reg + rot_mod;
        if (deg_step >= whm_pkg::FULL_TURN)
        begin
            deg_step = deg_step - whm_pkg::FULL_TURN;
        end
        cos_deg = deg_reg + whm_pkg::QUARTER_TURN;
        if (cos_deg >= whm_pkg::FULL_TURN)
        begin
            cos_deg = cos_deg - whm_pkg::FULL_TURN;
        end
    end

    // Magnitude of the sum being squared, split in low and high parts; root candidate and compare.
    logic signed [ACC_W-1:0] sq_src;
    logic [MAG_W-1:0]        mag;
    logic [LO_W-1:0]         mag_lo;
    logic [HI_W-1:0]         mag_hi;
    logic [whm_pkg::MOMENT_W-1:0] cand;
    logic [CMP_W-1:0]        lhs_cmp;
    logic [CMP_W-1:0]        rhs_cmp;

    always_comb
    begin
        sq_src = sq_sel_reg ? c_reg : s_reg;
        mag    = sq_src[ACC_W-1] ? MAG_W'(-sq_src) : MAG_W'(sq_src);
        mag_lo = mag[LO_W-1:0];
        mag_hi = mag[MAG_W-1:LO_W];
        cand   = m_reg | (whm_pkg::MOMENT_W'(1) << bit_reg);
        lhs_cmp = CMP_W'(prod[PW-1:0]) << 30;
        rhs_cmp = CMP_W'(x_reg);
    end

    // Multiplier operand selection.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        case (state_reg)
            whm_pkg::ST_MAC_SIN:
            begin
                op_a = whm_pkg::MUL_W'(rd_data_reg);
                op_b = whm_pkg::MUL_W'(whm_pkg::sine_deg(deg_reg));
            end
            whm_pkg::ST_MAC_COS:
            begin
                op_a = whm_pkg::MUL_W'(rd_data_reg);
                op_b = whm_pkg::MUL_W'(whm_pkg::sine_deg(cos_deg));
            end
            whm_pkg::ST_SQ_LO:
            begin
                op_a = $signed(whm_pkg::MUL_W'(mag_lo));
                op_b = $signed(whm_pkg::MUL_W'(mag_lo));
            end
            whm_pkg::ST_SQ_MID:
            begin
                op_a = $signed(whm_pkg::MUL_W'(mag_lo));
                op_b = $signed(whm_pkg::MUL_W'(mag_hi));
            end
            whm_pkg::ST_SQ_HI:
            begin
                op_a = $signed(whm_pkg::MUL_W'(mag_hi));
                op_b = $signed(whm_pkg::MUL_W'(mag_hi));
            end
            whm_pkg::ST_ROOT_MUL:
            begin
                op_a = $signed(whm_pkg::MUL_W'(cand));
                op_b = $signed(whm_pkg::MUL_W'(n_reg));
            end
            whm_pkg::ST_ROOT_SQ:
            begin
                op_a = $signed(whm_pkg::MUL_W'(prod[18:0]));
                op_b = $signed(whm_pkg::MUL_W'(prod[18:0]));
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            whm_pkg::ST_IDLE:
            begin
                if (accept && (n_sel != '0))
                begin
                    state_next = whm_pkg::ST_PREP;
                end
            end
            whm_pkg::ST_PREP:     state_next = whm_pkg::ST_MAC_SIN;
            whm_pkg::ST_MAC_SIN:  state_next = whm_pkg::ST_MAC_COS;
            whm_pkg::ST_MAC_COS:
            begin
                state_next = (k_reg == n_reg - CNT_W'(1)) ? whm_pkg::ST_DRAIN
                                                         : whm_pkg::ST_MAC_SIN;
            end
            whm_pkg::ST_DRAIN:    state_next = whm_pkg::ST_SQ_LO;
            whm_pkg::ST_SQ_LO:    state_next = whm_pkg::ST_SQ_MID;
            whm_pkg::ST_SQ_MID:   state_next = whm_pkg::ST_SQ_HI;
            whm_pkg::ST_SQ_HI:    state_next = whm_pkg::ST_SQ_END;
            whm_pkg::ST_SQ_END:
            begin
                state_next = sq_sel_reg ? whm_pkg::ST_ROOT_MUL : whm_pkg::ST_SQ_LO;
            end
            whm_pkg::ST_ROOT_MUL: state_next = whm_pkg::ST_ROOT_SQ;
            whm_pkg::ST_ROOT_SQ:  state_next = whm_pkg::ST_ROOT_CMP;
            whm_pkg::ST_ROOT_CMP:
            begin
                state_next = (bit_reg == 4'd0) ? whm_pkg::ST_OUT : whm_pkg::ST_ROOT_MUL;
            end
            whm_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = whm_pkg::ST_IDLE;
                end
            end
            default:              state_next = whm_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb
    begin
        in_ready  = (state_reg == whm_pkg::ST_IDLE);
        out_valid = (state_reg == whm_pkg::ST_OUT);
    end

    assign moment       = m_reg;
    assign window_used  = whm_pkg::USED_W'(n_reg);
    assign final_result = last_reg;

    // Control state, configuration and sequence pointers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= whm_pkg::ST_IDLE;
            wlen_reg  <= whm_pkg::WLEN_RESET;
            rot_reg   <= whm_pkg::ROT_RESET;
            wp_reg    <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    whm_pkg::REG_WINDOW_LENGTH: wlen_reg <= cfg_data[whm_pkg::WLEN_W-1:0];
                    whm_pkg::REG_ROTATION:      rot_reg  <= cfg_data[whm_pkg::ROT_W-1:0];
                    default:                    wlen_reg <= wlen_reg;
                endcase
            end
            if (accept)
            begin
                wp_reg   <= seq_end ? '0 : wp_new;
                fill_reg <= seq_end ? '0 : fill_new;
            end
        end
    end

    // Window store: written on an accepted beat, read through a registered port.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            store[wp_reg] <= hydro_value;
        end
        rd_data_reg <= $signed(store[rd_ptr_reg]);
    end

    // Datapath registers stepped by the sequencer.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            whm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    n_reg      <= n_sel;
                    last_reg   <= seq_end;
                    rd_ptr_reg <= PTR_W'(start_sum);
                end
                k_reg      <= '0;
                deg_reg    <= '0;
                s_reg      <= '0;
                c_reg      <= '0;
                x_reg      <= '0;
                sq_sel_reg <= 1'b0;
                m_reg      <= '0;
                bit_reg    <= 4'(whm_pkg::MOMENT_W - 1);
            end
            whm_pkg::ST_MAC_SIN:
            begin
                if (k_reg != '0)
                begin
                    c_reg <= c_reg + ACC_W'(prod);
                end
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            whm_pkg::ST_MAC_COS:
            begin
                s_reg   <= s_reg + ACC_W'(prod);
                k_reg   <= k_reg + CNT_W'(1);
                deg_reg <= deg_step;
            end
            whm_pkg::ST_DRAIN:
            begin
                c_reg <= c_reg + ACC_W'(prod);
            end
            whm_pkg::ST_SQ_MID:
            begin
                x_reg <= x_reg + XW'(prod[PW-1:0]);
            end
            whm_pkg::ST_SQ_HI:
            begin
                x_reg <= x_reg + (XW'(prod[PW-1:0]) << (LO_W + 1));
            end
            whm_pkg::ST_SQ_END:
            begin
                x_reg      <= x_reg + (XW'(prod[PW-1:0]) << (2 * LO_W));
                sq_sel_reg <= 1'b1;
            end
            whm_pkg::ST_ROOT_CMP:
            begin
                if (lhs_cmp <= rhs_cmp)
                begin
                    m_reg <= cand;
                end
                bit_reg <= bit_reg - 4'd1;
            end
            default:
            begin
                k_reg <= k_reg;
            end
        endcase
    end

    // A result beat and an input beat are never offered together.
    assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
        else $error("input and output offered in the same cycle");

    // A taken result beat frees the block in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready) |=> (in_ready && !out_valid))
        else $error("block not idle after result beat");

    // The window walk never passes the chosen window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == whm_pkg::ST_MAC_SIN) |-> (k_reg < n_reg))
        else $error("window index beyond window length");

    // A result always covers at least one residue and no more than the store holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((n_reg != '0) && (n_reg <= MAX_CNT)))
        else $error("result window length out of range");

endmodule

// ===== sim/windowed_hydrophobic_moment_tb.sv =====
// Self-checking testbench for the windowed hydrophobic moment block.
`timescale 1ns / 100ps

module windowed_hydrophobic_moment_tb;

    localparam int WIN_DEPTH = whm_pkg::MAX_WINDOW_DEF;

    typedef struct packed {
        logic [whm_pkg::MOMENT_W-1:0] moment;
        logic [whm_pkg::USED_W-1:0]   used;
        logic                         last;
    } moment_beat_t;

    logic                                clk;
    logic                                rst_n;
    logic                                cfg_we;
    logic                                cfg_index;
    logic [whm_pkg::CFG_W-1:0]           cfg_data;
    logic                                in_valid;
    logic                                in_ready;
    logic signed [whm_pkg::HYDRO_W-1:0]  hydro_value;
    logic                                seq_end;
    logic                                out_valid;
    logic                                out_ready;
    logic [whm_pkg::MOMENT_W-1:0]        moment;
    logic [whm_pkg::USED_W-1:0]          window_used;
    logic                                final_result;

    // Predictor state: residue store, pointers and register copies.
    int            hydro_store [WIN_DEPTH];
    int            store_ptr;
    int            residues_seen;
    int            win_len_reg;
    int            rot_reg;
    moment_beat_t  pending_moments [$];
    int            error_count;
    bit            no_gaps;
    logic [2:0]    ready_stall;

    windowed_hydrophobic_moment i_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .hydro_value  (hydro_value),
        .seq_end      (seq_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .moment       (moment),
        .window_used  (window_used),
        .final_result (final_result)
    );

    // Clock with a 10 ns period.
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Signed Q1.15 sine of a whole-degree angle, from the quarter-wave table.
    function automatic int sine_q15(input int deg);
        int d;
        begin
            d = deg % 360;
            if (d <= 90)
                sine_q15 = int'(whm_pkg::QSINE[d]);
            else if (d <= 180)
                sine_q15 = int'(whm_pkg::QSINE[180 - d]);
            else if (d <= 270)
                sine_q15 = -int'(whm_pkg::QSINE[d - 180]);
            else
                sine_q15 = -int'(whm_pkg::QSINE[360 - d]);
        end
    endfunction

    // Moment over the newest n residues: truncated root of S^2 + C^2, divided by n.
    function automatic logic [whm_pkg::MOMENT_W-1:0] window_moment(input int n);
        longint       s_sum;
        longint       c_sum;
        longint       s_abs;
        longint       c_abs;
        logic [127:0] energy;
        logic [127:0] cand;
        int           first;
        int           deg;
        int           bitpos;
        logic [10:0]  m;
        begin
            s_sum = 0;
            c_sum = 0;
            first = (store_ptr + WIN_DEPTH - n) % WIN_DEPTH;
            for (int k = 0; k < n; k++)
            begin
                deg = (k * rot_reg) % 360;
                s_sum += longint'(hydro_store[(first + k) % WIN_DEPTH]) * sine_q15(deg);
                c_sum += longint'(hydro_store[(first + k) % WIN_DEPTH]) * sine_q15(deg + 90);
            end
            s_abs = (s_sum < 0) ? -s_sum : s_sum;
            c_abs = (c_sum < 0) ? -c_sum : c_sum;
            energy = (128'(s_abs) * 128'(s_abs) + 128'(c_abs) * 128'(c_abs)) >> 30;
            m = '0;
            for (bitpos = 10; bitpos >= 0; bitpos--)
            begin
                cand = 128'(m | (11'd1 << bitpos));
                if (cand * cand * 128'(n * n) <= energy)
                    m = m | (11'd1 << bitpos);
            end
            window_moment = m;
        end
    endfunction

    // Advance the predictor by one accepted residue and queue any result.
    task automatic predict_residue(input logic signed [whm_pkg::HYDRO_W-1:0] h,
                                   input logic last);
        int           w;
        int           n;
        moment_beat_t beat;
        begin
            w = (win_len_reg == 0) ? 1 : (win_len_reg > WIN_DEPTH) ? WIN_DEPTH : win_len_reg;
            n = 0;
            hydro_store[store_ptr] = int'(h);
            store_ptr = (store_ptr + 1) % WIN_DEPTH;
            if (residues_seen < WIN_DEPTH)
                residues_seen++;
            if (residues_seen >= w)
                n = w;
            else if (last)
                n = residues_seen;
            if (n != 0)
            begin
                beat.moment = window_moment(n);
                beat.used   = whm_pkg::USED_W'(n);
                beat.last   = last;
                pending_moments.insert(pending_moments.size(), beat);
            end
            if (last)
            begin
                residues_seen = 0;
                store_ptr = 0;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
            error_count++;
        end
    endtask

    // Send one residue beat after a random gap unless no_gaps is set; returns at the accepting edge.
    task automatic send_residue(input logic signed [whm_pkg::HYDRO_W-1:0] h,
                                input logic last);
        int gap;
        begin
            gap = no_gaps ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid    <= 1'b1;
            hydro_value <= h;
            seq_end     <= last;
            do
                @(posedge clk);
            while (!in_ready);
            predict_residue(h, last);
        end
    endtask

    // Stop sending and wait until every expected result has arrived.
    task automatic wait_drained();
        begin
            in_valid <= 1'b0;
            while (pending_moments.size() != 0)
                @(posedge clk);
            repeat (150) @(posedge clk);
        end
    endtask

    // One register write; cfg_we is dropped again before the task returns.
    task automatic write_reg(input logic index, input int value);
        begin
            cfg_we    <= 1'b1;
            cfg_index <= index;
            cfg_data  <= whm_pkg::CFG_W'(value);
            @(posedge clk);
            cfg_we <= 1'b0;
            if (index == whm_pkg::REG_WINDOW_LENGTH)
                win_len_reg = value & 6'h3F;
            else
                rot_reg = value & 9'h1FF;
            @(posedge clk);
        end
    endtask

    task automatic send_random_sequence(input int len);
        begin
            for (int i = 0; i < len; i++)
                send_residue(whm_pkg::HYDRO_W'($urandom_range(0, 4095)), i == len - 1);
        end
    endtask

    // Reset values of the registers: alpha-helix angle, window of eleven.
    task automatic test_reset_config();
        begin
            send_random_sequence(14);
            wait_drained();
        end
    endtask

    // Field extremes, saturation, register clamping and short sequences.
    task automatic test_directed();
        begin
            write_reg(whm_pkg::REG_WINDOW_LENGTH, 32);
            write_reg(whm_pkg::REG_ROTATION, 0);
            for (int i = 0; i < 32; i++)
                send_residue(-12'sd2048, i == 31);
            wait_drained();
            write_reg(whm_pkg::REG_WINDOW_LENGTH, 0);
            write_reg(whm_pkg::REG_ROTATION, 359);
            send_residue(12'sd2047, 1'b0);
            send_residue(-12'sd2048, 1'b0);
            send_residue(12'sd0, 1'b1);
            wait_drained();
            write_reg(whm_pkg::REG_WINDOW_LENGTH, 63);
            write_reg(whm_pkg::REG_ROTATION, 511);
            send_residue(12'sd2047, 1'b1);
            send_residue(12'sd1, 1'b0);
            send_residue(-12'sd1, 1'b0);
            send_residue(12'sd2047, 1'b1);
            wait_drained();
            // Sequence shorter than the window ends with a clamped result.
            write_reg(whm_pkg::REG_WINDOW_LENGTH, 5);
            write_reg(whm_pkg::REG_ROTATION, 180);
            send_residue(12'sd256, 1'b0);
            send_residue(-12'sd256, 1'b0);
            send_residue(12'sd256, 1'b1);
            wait_drained();
        end
    endtask

    // Window shrinks and grows in the middle of a sequence.
    task automatic test_window_change();
        begin
            write_reg(whm_pkg::REG_WINDOW_LENGTH, 8);
            write_reg(whm_pkg::REG_ROTATION, 100);
            for (int i = 0; i < 10; i++)
                send_residue(whm_pkg::HYDRO_W'($urandom_range(0, 4095)), 1'b0);
            wait_drained();
            write_reg(whm_pkg::REG_WINDOW_LENGTH, 3);
            for (int i = 0; i < 4; i++)
                send_residue(whm_pkg::HYDRO_W'($urandom_range(0, 4095)), 1'b0);
            wait_drained();
            write_reg(whm_pkg::REG_WINDOW_LENGTH, 20);
            send_random_sequence(12);
            wait_drained();
        end
    endtask

    // Random phases: random settings, random sequence lengths and contents.
    task automatic test_random();
        int sent;
        int len;
        begin
            for (int phase = 0; phase < 6; phase++)
            begin
                no_gaps = (phase == 2);
                case (phase)
                    0: write_reg(whm_pkg::REG_WINDOW_LENGTH, 1);
                    5: write_reg(whm_pkg::REG_WINDOW_LENGTH, 32);
                    default: write_reg(whm_pkg::REG_WINDOW_LENGTH, $urandom_range(0, 63));
                endcase
                write_reg(whm_pkg::REG_ROTATION, (phase == 1) ? 0 : $urandom_range(0, 511));
                sent = 0;
                while (sent < 60)
                begin
                    len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, 40);
                    send_random_sequence(len);
                    sent += len;
                    // Once per phase the sender holds off until all results are in.
                    if (sent >= 40 && sent - len < 40)
                    begin
                        in_valid <= 1'b0;
                        do
                            @(posedge clk);
                        while (pending_moments.size() != 0);
                    end
                end
                wait_drained();
            end
            no_gaps = 1'b0;
        end
    endtask

    // Result side: random stalls and comparison against the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready   <= 1'b1;
            ready_stall <= '0;
        end
        else if (out_valid && out_ready)
        begin
            if (pending_moments.size() == 0)
            begin
                report_mismatch("expected result count", 1, 0);
            end
            else
            begin
                moment_beat_t want;
                want = pending_moments.pop_front();
                if (moment !== want.moment)
                    report_mismatch("moment", moment, want.moment);
                if (window_used !== want.used)
                    report_mismatch("window_used", window_used, want.used);
                if (final_result !== want.last)
                    report_mismatch("final_result", final_result, want.last);
            end
            ready_stall <= no_gaps ? 3'd0 : 3'($urandom_range(0, 7));
            out_ready   <= no_gaps ? 1'b1 : ($urandom_range(0, 7) == 0);
        end
        else if (ready_stall != 0)
        begin
            ready_stall <= ready_stall - 1'b1;
            out_ready   <= (ready_stall == 3'd1);
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Run limit.
    initial
    begin
        #5_000_000;
        $display("windowed_hydrophobic_moment_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = whm_pkg::REG_WINDOW_LENGTH;
        cfg_data      = '0;
        in_valid      = 1'b0;
        hydro_value   = '0;
        seq_end       = 1'b0;
        out_ready     = 1'b0;
        error_count   = 0;
        no_gaps       = 1'b0;
        store_ptr     = 0;
        residues_seen = 0;
        win_len_reg   = int'(whm_pkg::WLEN_RESET);
        rot_reg       = int'(whm_pkg::ROT_RESET);
        for (int i = 0; i < WIN_DEPTH; i++)
            hydro_store[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_config();
        test_directed();
        test_window_change();
        test_random();

        wait_drained();
        if (error_count == 0 && pending_moments.size() == 0)
            $display("windowed_hydrophobic_moment_tb: PASS");
        else
            $display("windowed_hydrophobic_moment_tb: FAIL");
        $finish;
    end

endmodule
